FILE: rtl/core/segmented_peak_level_meter_defines.svh
// Assertion macros for the checker file.
`ifndef SEGMENTED_PEAK_LEVEL_METER_DEFINES_SVH
`define SEGMENTED_PEAK_LEVEL_METER_DEFINES_SVH

// Clocked assertion, held off while reset is asserted.
`define SPLM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/splm_pkg.sv
package splm_pkg;

  // Default number of bars.
  localparam int BARS_DEF = 64;

  // Fixed field widths.
  localparam int SPB_W  = 11;
  localparam int CBAR_W = 7;
  localparam int SEG_W  = 10;
  localparam int LVL_W  = 16;

  // Segment length register.
  localparam logic [SPB_W-1:0] SPB_RST = 11'd16;
  localparam logic [SPB_W-1:0] SPB_MAX = 11'd1024;
  localparam logic             REG_SPB = 1'b0;

  // Shared multiplier operand and accumulator widths.
  localparam int OPA_W = 23;
  localparam int OPB_W = 24;
  localparam int ACC_W = OPA_W + OPB_W;

  // Division by 100: x / 100 == (x * DIV100_K) >> DIV100_SH for x < 2^23.
  localparam logic [OPB_W-1:0] DIV100_K  = 24'd10737419;
  localparam int               DIV100_SH = 30;

  // Weights in percent.
  localparam logic [OPB_W-1:0] W_ATK_OLD = 24'd30;
  localparam logic [OPB_W-1:0] W_ATK_NEW = 24'd70;
  localparam logic [OPB_W-1:0] W_DCY_OLD = 24'd92;
  localparam logic [OPB_W-1:0] W_DCY_NEW = 24'd8;
  localparam logic [OPB_W-1:0] W_HOLD    = 24'd97;
  localparam logic [OPB_W-1:0] W_IDLE_LV = 24'd90;
  localparam logic [OPB_W-1:0] W_IDLE_PK = 24'd95;
  localparam logic [OPB_W-1:0] W_ZERO    = 24'd0;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic               last;
  } splm_in_t;

  typedef struct packed {
    logic [5:0]       bar_index;
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] peak_hold;
    logic             last_bar;
  } splm_out_t;

  typedef struct packed {
    logic en;   // load the accumulator
    logic mac;  // add to it instead of replacing it
  } splm_alu_ctl_t;

endpackage

FILE: rtl/core/segmented_peak_level_meter.sv
// Channel   Handshake            Payload                        Direction
// in        in_valid_i/in_stall_o  in_data_i  (kind,sample,last)  into block
// out       out_valid_o/out_stall_i out_data_o (bar,level,peak,last) out of block
// cfg       APB psel/penable     paddr/pwdata/prdata            host access
//
// A sample that closes no segment is taken without leaving idle. Every bar
// update runs through the single shared multiplier in order (read, load, five
// multiply steps, write back); a frame end updates each remaining bar and an
// idle tick updates every bar. The input stalls while bars are being updated.
// Reset clears the frame tracking and marks every bar entry as zero.
// An output stall holds the write-back step until the result register frees.
module segmented_peak_level_meter #(
  parameter int BARS = splm_pkg::BARS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input transactions
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  splm_pkg::splm_in_t  in_data_i,
  // result transactions
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output splm_pkg::splm_out_t out_data_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int BAR_AW = (BARS > 1) ? $clog2(BARS) : 1;
  localparam logic [splm_pkg::CBAR_W-1:0] BAR_LAST = splm_pkg::CBAR_W'(BARS - 1);
  localparam logic [splm_pkg::CBAR_W-1:0] BAR_CNT  = splm_pkg::CBAR_W'(BARS);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;  // issue the bar store read
  localparam logic [3:0] S_LD   = 4'd2;  // capture level and held peak
  localparam logic [3:0] S_M1   = 4'd3;  // old level times its weight
  localparam logic [3:0] S_M2   = 4'd4;  // add target times its weight
  localparam logic [3:0] S_M3   = 4'd5;  // divide the level sum by 100
  localparam logic [3:0] S_M4   = 4'd6;  // held peak times decay weight
  localparam logic [3:0] S_M5   = 4'd7;  // divide it by 100
  localparam logic [3:0] S_WB   = 4'd8;  // write back and emit

  logic [3:0] st_q, st_d;

  // Configuration.
  logic [splm_pkg::SPB_W-1:0] spb_q;
  logic [splm_pkg::SPB_W-1:0] spb_eff;
  logic                       cfg_we;

  // Frame tracking.
  logic [15:0]                 rp_q;
  logic [splm_pkg::CBAR_W-1:0] cur_q;
  logic [splm_pkg::SEG_W-1:0]  seg_q;
  logic [1:0]                  fss_q;

  // Work registers for the bar being updated.
  logic                             dec_q;
  logic [splm_pkg::CBAR_W-1:0]      b_q, end_q;
  logic [splm_pkg::LVL_W-1:0]       t_q, s_q, h_q, sn_q;
  logic [BARS-1:0]                  vld_q;

  // Result register.
  logic                 ovld_q;
  splm_pkg::splm_out_t  out_q;

  // Accept-time decode.
  logic                        in_acc;
  logic [16:0]                 mag17;
  logic [15:0]                 mag, rp_new;
  logic [splm_pkg::SPB_W-1:0]  seg_new;
  logic [17:0]                 t3;
  logic [splm_pkg::LVL_W-1:0]  t_sat;
  logic                        in_range, complete, go_dec, go_upd;

  // Shared unit and store.
  splm_pkg::splm_alu_ctl_t     alu_ctl;
  logic [splm_pkg::OPA_W-1:0]  alu_a;
  logic [splm_pkg::OPB_W-1:0]  alu_b;
  logic [splm_pkg::ACC_W-1:0]  acc;
  logic [splm_pkg::LVL_W-1:0]  quot;
  logic [31:0]                 ram_rdata;
  logic                        gt_s, gt_h;
  logic [splm_pkg::LVL_W-1:0]  hn;
  logic                        emit;
  logic                        bar_done;

  // APB: one register, word aligned; other addresses read zero.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == splm_pkg::REG_SPB);
  assign prdata = (paddr[2] == splm_pkg::REG_SPB) ? 32'(spb_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q <= splm_pkg::SPB_RST;
    end else if (cfg_we) begin
      spb_q <= pwdata[splm_pkg::SPB_W-1:0];
    end
  end

  // Clamp the segment length to 1..1024.
  always_comb begin
    spb_eff = spb_q;
    if (spb_q == '0) begin
      spb_eff = splm_pkg::SPB_W'(1);
    end else if (spb_q > splm_pkg::SPB_MAX) begin
      spb_eff = splm_pkg::SPB_MAX;
    end
  end

  assign in_stall_o = (st_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Magnitude in Q1.15 units; full negative scale gives 32768.
  assign mag17    = in_data_i.sample[15] ? (17'h10000 - {1'b0, in_data_i.sample})
                                         : {1'b0, in_data_i.sample};
  assign mag      = mag17[15:0];
  assign rp_new   = (mag > rp_q) ? mag : rp_q;
  assign seg_new  = splm_pkg::SPB_W'(seg_q) + splm_pkg::SPB_W'(1);
  assign in_range = (cur_q < BAR_CNT);
  assign complete = in_range && (seg_new >= spb_eff);
  // Idle tick or a single-sample frame: decay every bar.
  assign go_dec   = in_data_i.kind || ((fss_q == 2'd0) && in_data_i.last);
  assign go_upd   = !go_dec && in_range && (complete || in_data_i.last);

  // Target: 1.5 times the peak on the Q0.16 scale, saturated.
  assign t3    = {1'b0, rp_new, 1'b0} + {2'b00, rp_new};
  assign t_sat = (t3 > 18'd65535) ? 16'hFFFF : t3[15:0];

  assign gt_s = (t_q > s_q);
  assign gt_h = (t_q > h_q);
  assign quot = acc[splm_pkg::DIV100_SH +: splm_pkg::LVL_W];
  assign hn   = (!dec_q && gt_h) ? t_q : quot;

  assign bar_done = (b_q == end_q);
  assign emit     = (st_q == S_WB) && (!ovld_q || !out_stall_i);

  // Operand selection for the shared multiplier.
  always_comb begin
    alu_ctl = '0;
    alu_a   = '0;
    alu_b   = '0;
    case (st_q)
      S_M1: begin
        alu_ctl.en = 1'b1;
        alu_a      = splm_pkg::OPA_W'(s_q);
        alu_b      = dec_q ? splm_pkg::W_IDLE_LV
                           : (gt_s ? splm_pkg::W_ATK_OLD : splm_pkg::W_DCY_OLD);
      end
      S_M2: begin
        alu_ctl.en  = 1'b1;
        alu_ctl.mac = 1'b1;
        alu_a       = splm_pkg::OPA_W'(t_q);
        alu_b       = dec_q ? splm_pkg::W_ZERO
                            : (gt_s ? splm_pkg::W_ATK_NEW : splm_pkg::W_DCY_NEW);
      end
      S_M3, S_M5: begin
        alu_ctl.en = 1'b1;
        alu_a      = acc[splm_pkg::OPA_W-1:0];
        alu_b      = splm_pkg::DIV100_K;
      end
      S_M4: begin
        alu_ctl.en = 1'b1;
        alu_a      = splm_pkg::OPA_W'(h_q);
        alu_b      = dec_q ? splm_pkg::W_IDLE_PK : splm_pkg::W_HOLD;
      end
      default: begin
        alu_ctl = '0;
      end
    endcase
  end

  splm_alu u_alu (
    .clk_i (clk_i),
    .ctl_i (alu_ctl),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .acc_o (acc)
  );

  // Bar store: level in the upper half, held peak in the lower half.
  splm_ram #(
    .WIDTH (32),
    .DEPTH (BARS)
  ) u_bar_ram (
    .clk_i   (clk_i),
    .we_i    (emit),
    .waddr_i (b_q[BAR_AW-1:0]),
    .wdata_i ({sn_q, hn}),
    .re_i    (st_q == S_RD),
    .raddr_i (b_q[BAR_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Next-state logic.
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (in_acc && (go_dec || go_upd)) begin
          st_d = S_RD;
        end
      end
      S_RD:  st_d = S_LD;
      S_LD:  st_d = S_M1;
      S_M1:  st_d = S_M2;
      S_M2:  st_d = S_M3;
      S_M3:  st_d = S_M4;
      S_M4:  st_d = S_M5;
      S_M5:  st_d = S_WB;
      S_WB: begin
        if (emit) begin
          st_d = bar_done ? S_IDLE : S_RD;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Control state: sequencer, frame tracking, entry valid bits, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      rp_q   <= '0;
      cur_q  <= '0;
      seg_q  <= '0;
      fss_q  <= '0;
      vld_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q <= st_d;

      if (in_acc) begin
        if (go_dec || in_data_i.last) begin
          // Drop any partial frame.
          rp_q  <= '0;
          cur_q <= '0;
          seg_q <= '0;
          fss_q <= '0;
        end else begin
          if (fss_q != 2'd2) begin
            fss_q <= fss_q + 2'd1;
          end
          if (complete) begin
            cur_q <= cur_q + splm_pkg::CBAR_W'(1);
            rp_q  <= '0;
            seg_q <= '0;
          end else if (in_range) begin
            rp_q  <= rp_new;
            seg_q <= seg_new[splm_pkg::SEG_W-1:0];
          end
        end
      end

      if (emit) begin
        vld_q[b_q[BAR_AW-1:0]] <= 1'b1;
        ovld_q                 <= 1'b1;
      end else if (!out_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // Work and result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (go_dec) begin
        dec_q <= 1'b1;
        b_q   <= '0;
        end_q <= BAR_LAST;
        t_q   <= '0;
      end else begin
        // First bar takes the open segment's peak; the rest of a flush take zero.
        dec_q <= 1'b0;
        b_q   <= cur_q;
        end_q <= in_data_i.last ? BAR_LAST : cur_q;
        t_q   <= t_sat;
      end
    end

    if (st_q == S_LD) begin
      // Unwritten entries read as zero.
      s_q <= vld_q[b_q[BAR_AW-1:0]] ? ram_rdata[31:16] : '0;
      h_q <= vld_q[b_q[BAR_AW-1:0]] ? ram_rdata[15:0]  : '0;
    end

    if (st_q == S_M4) begin
      sn_q <= quot;
    end

    if (emit) begin
      out_q.bar_index <= b_q[5:0];
      out_q.level     <= sn_q;
      out_q.peak_hold <= hn;
      out_q.last_bar  <= bar_done;
      if (!bar_done) begin
        b_q <= b_q + splm_pkg::CBAR_W'(1);
        t_q <= '0;
      end
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/splm_ram.sv
module splm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = splm_pkg::BARS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/splm_alu.sv
module splm_alu (
  input  logic                          clk_i,
  input  splm_pkg::splm_alu_ctl_t       ctl_i,
  input  logic [splm_pkg::OPA_W-1:0]    a_i,
  input  logic [splm_pkg::OPB_W-1:0]    b_i,
  output logic [splm_pkg::ACC_W-1:0]    acc_o
);

  logic [splm_pkg::ACC_W-1:0] prod;
  logic [splm_pkg::ACC_W-1:0] acc_d, acc_q;

  assign prod  = splm_pkg::ACC_W'(a_i) * splm_pkg::ACC_W'(b_i);
  assign acc_d = ctl_i.mac ? acc_q + prod : prod;

  // Hold the accumulator unless a step is issued.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/core/splm_chk.sv
`include "segmented_peak_level_meter_defines.svh"

module splm_chk #(
  parameter int BARS = splm_pkg::BARS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input splm_pkg::splm_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input splm_pkg::splm_out_t out_data_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);

  logic unused_cfg;
  assign unused_cfg = psel ^ penable ^ pwrite ^ (^paddr) ^ (^pwdata) ^ (^prdata) ^ pready;

  `SPLM_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o)), "stalled result changed")
  `SPLM_ASSERT(a_bar_range, clk_i, rst_ni, (out_valid_o |-> (out_data_o.bar_index <= 6'(BARS - 1))), "bar index out of range")
  `SPLM_ASSERT(a_tick_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o && in_data_i.kind |=> in_stall_o), "idle tick did not start a bar sweep")
  `SPLM_ASSERT(a_sweep_cont, clk_i, rst_ni, (out_valid_o && !out_stall_i && !out_data_o.last_bar |=> out_valid_o || in_stall_o), "sweep ended without a final result")
  `SPLM_ASSERT_ALWAYS(a_rst_quiet, clk_i, (!rst_ni |=> !out_valid_o), "result shown during reset")

endmodule

bind segmented_peak_level_meter splm_chk #(.BARS(BARS)) u_splm_chk (.*);
